// ===== rtl/bidm_pkg.sv =====
// Package for the bidirectional ID map table.
// Table size, operation and status codes, entry and control structs.
// No dependencies.
package bidm_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned IdW  = 32;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpDelete = 2'd1,
    OpSearch = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StsInserted = 3'd0,
    StsExists   = 3'd1,
    StsConflict = 3'd2,
    StsFound    = 3'd3,
    StsNotFound = 3'd4,
    StsFull     = 3'd5,
    StsDone     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SResult
  } state_e;

  typedef struct packed {
    logic           is_group;
    logic [IdW-1:0] client;
    logic [IdW-1:0] fs;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e        status;
    logic [IdW-1:0] client;
    logic [IdW-1:0] fs;
  } result_t;

endpackage

// ===== rtl/bidm_if.sv =====
// Request and response channel interfaces of the ID map table.
// Depends on bidm_pkg.
interface bidm_req_if import bidm_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [1:0]     op;
  logic           id_kind;
  logic           direction;
  logic [IdW-1:0] cl_id;
  logic [IdW-1:0] fs_id;
  logic [IdW-1:0] search_key;

  modport source (output valid, op, id_kind, direction, cl_id, fs_id, search_key,
                  input ready);
  modport sink   (input valid, op, id_kind, direction, cl_id, fs_id, search_key,
                  output ready);
endinterface

interface bidm_rsp_if import bidm_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [2:0]     status;
  logic [IdW-1:0] match_client;
  logic [IdW-1:0] match_fs;

  modport source (output valid, status, match_client, match_fs, input ready);
  modport sink   (input valid, status, match_client, match_fs, output ready);
endinterface

// ===== rtl/bidm_ram.sv =====
// Entry storage: one write port, one read port, registered read data.
// Depends on bidm_pkg.
module bidm_ram import bidm_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output entry_t   rdata_o
);

  entry_t mem [TableEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bidm_ctrl.sv =====
// Scan sequencer: valid bits, request capture, entry-by-entry compare,
// result selection and table update. Depends on bidm_pkg.
module bidm_ctrl import bidm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  op_e            op_i,
  input  logic           kind_i,
  input  logic           dir_i,
  input  logic [IdW-1:0] cid_i,
  input  logic [IdW-1:0] fid_i,
  input  logic [IdW-1:0] key_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output result_t        res_o,
  output mem_req_t       mem_req_o,
  input  entry_t         rdata_i
);

  state_e state_q, state_d;
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;

  op_e            op_q, op_d;
  logic           kind_q, kind_d;
  logic           dir_q, dir_d;
  logic [IdW-1:0] cid_q, cid_d, fid_q, fid_d, key_q, key_d;

  logic            chit_q, chit_d, fhit_q, fhit_d, hit_q, hit_d, free_q, free_d;
  entry_t          cent_q, cent_d, fent_q, fent_d, hent_q, hent_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;

  logic accept, scan_last, live, c_eq, f_eq, k_eq, hit_now, done;

  assign accept    = req_valid_i && req_ready_o;
  assign scan_last = (cnt_q == CntW'(TableEntries));
  assign done      = (state_q == SResult) && res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = (op_i == OpClear) ? SResult : SScan;
        end
      end
      SScan: begin
        if (scan_last) begin
          state_d = SResult;
        end
      end
      SResult: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // compare of the entry read last cycle
  assign live = chk_vld_q && valid_q[chk_idx_q] && (rdata_i.is_group == kind_q);
  assign c_eq = (rdata_i.client == cid_q);
  assign f_eq = (rdata_i.fs == fid_q);
  assign k_eq = dir_q ? (rdata_i.client == key_q) : (rdata_i.fs == key_q);

  always_comb begin
    case (op_q)
      OpDelete: hit_now = live && c_eq && f_eq;
      OpSearch: hit_now = live && k_eq;
      default:  hit_now = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    op_d       = op_q;
    kind_d     = kind_q;
    dir_d      = dir_q;
    cid_d      = cid_q;
    fid_d      = fid_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = cnt_q[IdxW-1:0];
    chit_d     = chit_q;
    fhit_d     = fhit_q;
    hit_d      = hit_q;
    free_d     = free_q;
    cent_d     = cent_q;
    fent_d     = fent_q;
    hent_d     = hent_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;

    if (accept) begin
      op_d   = op_i;
      kind_d = kind_i;
      dir_d  = dir_i;
      cid_d  = cid_i;
      fid_d  = fid_i;
      key_d  = key_i;
      cnt_d  = '0;
      chit_d = 1'b0;
      fhit_d = 1'b0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end

    if (state_q == SScan && !scan_last) begin
      cnt_d     = cnt_q + CntW'(1);
      chk_vld_d = 1'b1;
    end

    if (chk_vld_q) begin
      if (live && c_eq && !chit_q) begin
        chit_d = 1'b1;
        cent_d = rdata_i;
      end
      if (live && f_eq && !fhit_q) begin
        fhit_d = 1'b1;
        fent_d = rdata_i;
      end
      if (hit_now && !hit_q) begin
        hit_d     = 1'b1;
        hent_d    = rdata_i;
        hit_idx_d = chk_idx_q;
      end
      if (!valid_q[chk_idx_q] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end

    if (done) begin
      case (op_q)
        OpInsert: begin
          if (!chit_q && !fhit_q && free_q) begin
            valid_d[free_idx_q] = 1'b1;
          end
        end
        OpDelete: begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
          end
        end
        OpClear:  valid_d = '0;
        default:  ;
      endcase
    end
  end

  // outputs
  always_comb begin
    req_ready_o = (state_q == SIdle);
    res_valid_o = (state_q == SResult);

    mem_req_o.raddr          = cnt_q[IdxW-1:0];
    mem_req_o.waddr          = free_idx_q;
    mem_req_o.wdata.is_group = kind_q;
    mem_req_o.wdata.client   = cid_q;
    mem_req_o.wdata.fs       = fid_q;
    mem_req_o.we             = done && (op_q == OpInsert) && !chit_q && !fhit_q && free_q;

    res_o.status = StsDone;
    res_o.client = '0;
    res_o.fs     = '0;
    case (op_q)
      OpInsert: begin
        if (chit_q && fhit_q) begin
          res_o.status = StsExists;
        end else if (chit_q) begin
          res_o.status = StsConflict;
          res_o.client = cent_q.client;
          res_o.fs     = cent_q.fs;
        end else if (fhit_q) begin
          res_o.status = StsConflict;
          res_o.client = fent_q.client;
          res_o.fs     = fent_q.fs;
        end else if (!free_q) begin
          res_o.status = StsFull;
        end else begin
          res_o.status = StsInserted;
        end
      end
      OpDelete: res_o.status = hit_q ? StsDone : StsNotFound;
      OpSearch: begin
        if (hit_q) begin
          res_o.status = StsFound;
          res_o.client = hent_q.client;
          res_o.fs     = hent_q.fs;
        end else begin
          res_o.status = StsNotFound;
        end
      end
      default: res_o.status = StsDone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      valid_q   <= '0;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    kind_q     <= kind_d;
    dir_q      <= dir_d;
    cid_q      <= cid_d;
    fid_q      <= fid_d;
    key_q      <= key_d;
    chk_idx_q  <= chk_idx_d;
    chit_q     <= chit_d;
    fhit_q     <= fhit_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    cent_q     <= cent_d;
    fent_q     <= fent_d;
    hent_q     <= hent_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

endmodule

// ===== rtl/bidirectional_id_map_table.sv =====
// Top level of the bidirectional ID map table: entry RAM, scan controller
// and response register. Depends on bidm_pkg, bidm_if, bidm_ram, bidm_ctrl.
//
//   channel  modport            payload
//   req      bidm_req_if.sink   op, id_kind, direction, cl_id, fs_id, search_key
//   rsp      bidm_rsp_if.source status, match_client, match_fs
//
// Insert, delete and search read every entry once through the RAM read port;
// Clear skips the scan and goes straight to the result state. The scanner
// works on one request at a time; req.ready is high again as soon as the
// result sits in the response register.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled response holds its result; the next request is still taken and
// scanned, and its result then waits in the controller until the register frees.
module bidirectional_id_map_table import bidm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bidm_req_if.sink          req,
  bidm_rsp_if.source        rsp
);

  mem_req_t mem_req;
  entry_t   rdata;
  result_t  res;
  logic     res_valid, res_ready;
  logic     rsp_vld_q, rsp_vld_d;
  result_t  rsp_q;

  bidm_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  bidm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .op_i        (op_e'(req.op)),
    .kind_i      (req.id_kind),
    .dir_i       (req.direction),
    .cid_i       (req.cl_id),
    .fid_i       (req.fs_id),
    .key_i       (req.search_key),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata)
  );

  assign res_ready = !rsp_vld_q || rsp.ready;

  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (rsp.ready) begin
      rsp_vld_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      rsp_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid        = rsp_vld_q;
  assign rsp.status       = rsp_q.status;
  assign rsp.match_client = rsp_q.client;
  assign rsp.match_fs     = rsp_q.fs;

endmodule

// ===== tb/sv/bidirectional_id_map_table_tb.sv =====
// Testbench for bidirectional_id_map_table: drives requests and checks every response
// against an internal model of the user and group ID map table.
// Depends on bidm_pkg, bidm_req_if, bidm_rsp_if and the RTL top level.
module bidirectional_id_map_table_tb;
  import bidm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindUser   = 1'b0;
  localparam logic KindGroup  = 1'b1;
  localparam logic DirFs      = 1'b0;
  localparam logic DirClient  = 1'b1;
  localparam logic [IdW-1:0] IdZero = '0;
  localparam logic [IdW-1:0] IdOnes = '1;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = TableEntries + 8;
  localparam int HoldOffCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  bidm_req_if req_ch ();
  bidm_rsp_if rsp_ch ();

  bidirectional_id_map_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model of the table contents
  logic           map_live   [TableEntries];
  logic           map_group  [TableEntries];
  logic [IdW-1:0] map_client [TableEntries];
  logic [IdW-1:0] map_fs     [TableEntries];

  result_t        pending_answers[$];
  logic [IdW-1:0] id_pool [16];
  int             err_count  = 0;
  int             cycle_count = 0;
  int             gap_max    = 6;
  int             stall_max  = 6;
  int             rsp_hold   = 0;

  function automatic result_t apply_map_request(op_e op, logic kind, logic dir,
                                                logic [IdW-1:0] cid, logic [IdW-1:0] fid,
                                                logic [IdW-1:0] key);
    result_t res;
    int c_hit, f_hit, free_idx, hit, i;
    c_hit = -1;
    f_hit = -1;
    free_idx = -1;
    hit = -1;
    res.status = StsNotFound;
    res.client = '0;
    res.fs = '0;
    case (op)
      OpInsert: begin
        for (i = 0; i < TableEntries; i++) begin
          if (map_live[i] && map_group[i] == kind) begin
            if (c_hit < 0 && map_client[i] == cid) c_hit = i;
            if (f_hit < 0 && map_fs[i] == fid) f_hit = i;
          end else if (!map_live[i] && free_idx < 0) begin
            free_idx = i;
          end
        end
        if (c_hit >= 0 && f_hit >= 0) begin
          res.status = StsExists;
        end else if (c_hit >= 0 || f_hit >= 0) begin
          hit = (c_hit >= 0) ? c_hit : f_hit;
          res.status = StsConflict;
          res.client = map_client[hit];
          res.fs = map_fs[hit];
        end else if (free_idx < 0) begin
          res.status = StsFull;
        end else begin
          map_live[free_idx] = 1'b1;
          map_group[free_idx] = kind;
          map_client[free_idx] = cid;
          map_fs[free_idx] = fid;
          res.status = StsInserted;
        end
      end
      OpDelete: begin
        for (i = 0; i < TableEntries && hit < 0; i++) begin
          if (map_live[i] && map_group[i] == kind && map_client[i] == cid &&
              map_fs[i] == fid) hit = i;
        end
        if (hit >= 0) begin
          map_live[hit] = 1'b0;
          res.status = StsDone;
        end
      end
      OpSearch: begin
        for (i = 0; i < TableEntries && hit < 0; i++) begin
          if (map_live[i] && map_group[i] == kind &&
              ((dir == DirClient) ? map_client[i] : map_fs[i]) == key) hit = i;
        end
        if (hit >= 0) begin
          res.status = StsFound;
          res.client = map_client[hit];
          res.fs = map_fs[hit];
        end
      end
      default: begin
        for (i = 0; i < TableEntries; i++) map_live[i] = 1'b0;
        res.status = StsDone;
      end
    endcase
    return res;
  endfunction

  function automatic int pick_live_slot();
    int slots[$];
    for (int i = 0; i < TableEntries; i++) if (map_live[i]) slots.push_back(i);
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(slots.size() - 1, 0)];
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < TableEntries; i++) if (map_live[i]) n++;
    return n;
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    int r;
    r = $urandom_range(9, 0);
    if (r < 6) return id_pool[$urandom_range(15, 0)];
    return $urandom();
  endfunction

  task automatic send_req(op_e op, logic kind, logic dir, logic [IdW-1:0] cid,
                          logic [IdW-1:0] fid, logic [IdW-1:0] key);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.id_kind    <= kind;
    req_ch.direction  <= dir;
    req_ch.cl_id      <= cid;
    req_ch.fs_id      <= fid;
    req_ch.search_key <= key;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    pending_answers.push_back(apply_map_request(op, kind, dir, cid, fid, key));
  endtask

  task automatic random_request();
    int r, slot;
    logic kind, dir;
    logic [IdW-1:0] cid, fid, key;
    r = $urandom_range(99, 0);
    kind = 1'($urandom_range(1, 0));
    dir = 1'($urandom_range(1, 0));
    cid = pick_id();
    fid = pick_id();
    key = pick_id();
    slot = pick_live_slot();
    if (r < 40) begin
      send_req(OpInsert, kind, dir, cid, fid, key);
    end else if (r < 60) begin
      if (slot >= 0 && $urandom_range(9, 0) < 7) begin
        kind = map_group[slot];
        cid = map_client[slot];
        fid = map_fs[slot];
      end
      send_req(OpDelete, kind, dir, cid, fid, key);
    end else if (r < 97) begin
      if (slot >= 0 && $urandom_range(9, 0) < 6) begin
        kind = map_group[slot];
        key = (dir == DirClient) ? map_client[slot] : map_fs[slot];
      end
      send_req(OpSearch, kind, dir, cid, fid, key);
    end else begin
      send_req(OpClear, kind, dir, cid, fid, key);
    end
  endtask

  task automatic test_directed_cases();
    send_req(OpSearch, KindUser, DirFs, $urandom(), $urandom(), IdZero);
    send_req(OpDelete, KindUser, DirClient, IdZero, IdOnes, $urandom());
    send_req(OpInsert, KindUser, DirFs, IdZero, IdOnes, $urandom());
    send_req(OpInsert, KindUser, DirClient, IdZero, IdOnes, $urandom());
    send_req(OpInsert, KindUser, DirFs, IdZero, 32'd5, $urandom());
    send_req(OpInsert, KindUser, DirFs, 32'd7, IdOnes, $urandom());
    send_req(OpInsert, KindGroup, DirClient, IdZero, IdOnes, $urandom());
    send_req(OpInsert, KindUser, DirFs, IdOnes, IdZero, $urandom());
    // both IDs held, on different entries
    send_req(OpInsert, KindUser, DirFs, IdZero, IdZero, $urandom());
    send_req(OpInsert, KindUser, DirClient, IdOnes, IdOnes, $urandom());
    send_req(OpSearch, KindUser, DirClient, $urandom(), $urandom(), IdZero);
    send_req(OpSearch, KindUser, DirFs, $urandom(), $urandom(), IdZero);
    send_req(OpSearch, KindGroup, DirFs, $urandom(), $urandom(), IdZero);
    send_req(OpSearch, KindGroup, DirClient, $urandom(), $urandom(), IdZero);
    send_req(OpDelete, KindUser, DirFs, IdZero, IdZero, $urandom());
    send_req(OpDelete, KindGroup, DirFs, IdZero, IdOnes, $urandom());
    send_req(OpDelete, KindUser, DirClient, IdZero, IdOnes, $urandom());
    send_req(OpInsert, KindUser, DirFs, 32'd1, 32'd2, $urandom());
    send_req(OpSearch, KindUser, DirClient, $urandom(), $urandom(), 32'd2);
    send_req(OpClear, KindGroup, DirClient, IdOnes, IdOnes, IdOnes);
    send_req(OpSearch, KindUser, DirClient, $urandom(), $urandom(), IdOnes);
    send_req(OpClear, KindUser, DirFs, IdZero, IdZero, IdZero);
  endtask

  task automatic test_table_full();
    int slot;
    logic [IdW-1:0] cid, fid;
    while (live_count() < TableEntries)
      send_req(OpInsert, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
               $urandom(), $urandom(), $urandom());
    repeat (3)
      send_req(OpInsert, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
               $urandom(), $urandom(), $urandom());
    slot = pick_live_slot();
    send_req(OpDelete, map_group[slot], 1'($urandom_range(1, 0)), map_client[slot],
             map_fs[slot], $urandom());
    cid = $urandom();
    fid = $urandom();
    send_req(OpInsert, KindGroup, DirFs, cid, fid, $urandom());
    send_req(OpSearch, KindGroup, DirClient, $urandom(), $urandom(), cid);
    send_req(OpSearch, KindGroup, DirFs, $urandom(), $urandom(), fid);
    send_req(OpInsert, KindUser, DirFs, $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    stall_max = 0;
    rsp_hold = HoldOffCycles;
    repeat (16) random_request();
    gap_max = 6;
    stall_max = 6;
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 440; n++) begin
      if (n % 110 == 0) begin
        case (n / 110)
          0: begin gap_max = 6; stall_max = 6; end
          1: begin gap_max = 0; stall_max = 0; end
          2: begin gap_max = 6; stall_max = 0; end
          default: begin gap_max = 0; stall_max = 6; end
        endcase
      end
      random_request();
    end
  endtask

  // Response side: per-transfer stall, plus an occasional long hold-off
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rsp_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rsp_hold) @(posedge clk_i);
        rsp_hold = 0;
      end
      n = $urandom_range(stall_max, 0);
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i);
      while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) && rsp_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("response transfer with no request outstanding");
        err_count++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.match_client !== want.client) begin
          $error("match_client: expected %08h, got %08h", want.client, rsp_ch.match_client);
          err_count++;
        end
        if (rsp_ch.match_fs !== want.fs) begin
          $error("match_fs: expected %08h, got %08h", want.fs, rsp_ch.match_fs);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OpSearch;
    req_ch.id_kind    <= KindUser;
    req_ch.direction  <= DirFs;
    req_ch.cl_id      <= '0;
    req_ch.fs_id      <= '0;
    req_ch.search_key <= '0;
    for (int i = 0; i < TableEntries; i++) begin
      map_live[i] = 1'b0;
      map_group[i] = KindUser;
      map_client[i] = '0;
      map_fs[i] = '0;
    end
    id_pool[0] = IdZero;
    id_pool[1] = IdOnes;
    for (int i = 2; i < 16; i++) id_pool[i] = $urandom();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_table_full();
    test_backpressure();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
